// File: rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg: shared types and helpers for the associated Legendre evaluator
// State codes, status codes, unit request and response records, and the
// saturating conversions used by the datapath and its arithmetic units.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  localparam logic [63:0] INT64_MAX_U = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN_U = 64'h8000_0000_0000_0000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_SQRT, ST_ROOT, ST_POW, ST_POW_W, ST_DFAC, ST_DFAC_W,
    ST_SIGN, ST_X1, ST_X1_W, ST_X1B, ST_X1B_W, ST_LOOP, ST_LA_W, ST_LA2,
    ST_LA2_W, ST_LB, ST_LB_W, ST_LDIV, ST_LDIV_W, ST_SCALE, ST_DPROD,
    ST_DPROD_W, ST_FDIV, ST_FDIV_W, ST_DONE
  } state_t;

  typedef struct packed {
    logic               start;
    logic               fix;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic        rnd;
    logic        neg;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               sat;
    logic signed [63:0] val;
  } unit_rsp_t;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } sat_res_t;

  function automatic sat_res_t from_mag(input logic neg, input logic [63:0] q);
    logic [63:0] lim;
    logic [63:0] qq;
    sat_res_t    res;
    lim     = neg ? INT64_MIN_U : INT64_MAX_U;
    qq      = q;
    res.sat = 1'b0;
    if (q > lim) begin
      qq      = lim;
      res.sat = 1'b1;
    end
    res.val = neg ? $signed(-qq) : $signed(qq);
    return res;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic sat_res_t sub_sat(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    logic signed [64:0] d;
    sat_res_t           res;
    d       = 65'(a) - 65'(b);
    res.sat = 1'b0;
    res.val = d[63:0];
    if (d > $signed({1'b0, INT64_MAX_U})) begin
      res.sat = 1'b1;
      res.val = $signed(INT64_MAX_U);
    end else if (d < $signed({1'b1, INT64_MIN_U})) begin
      res.sat = 1'b1;
      res.val = $signed(INT64_MIN_U);
    end
    return res;
  endfunction

endpackage

// File: rtl/ale_mul.sv
// ----------------------------------------------------------------------------
// ale_mul: shared multi-cycle signed multiplier
// Forms a 64 by 64 magnitude product from four 32 by 32 partial products,
// then rounds and scales for fixed point or passes the integer product, and
// saturates to the signed 64-bit range.
// ----------------------------------------------------------------------------
module ale_mul #(
  parameter int FRAC_BITS = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  ale_pkg::mul_req_t req,
  output ale_pkg::unit_rsp_t rsp
);
  import ale_pkg::*;

  localparam logic [128:0] RND = 129'(1) << (FRAC_BITS - 1);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic         fixm;
  logic [127:0] acc;
  logic [1:0]   cnt;
  logic         busy;
  logic         fin;
  logic [31:0]  a_sel;
  logic [31:0]  b_sel;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [128:0] t;
  logic [128:0] sh;
  logic         ovf;
  logic [63:0]  q;
  sat_res_t     res;

  always_comb begin
    a_sel = cnt[1] ? ma[63:32] : ma[31:0];
    b_sel = cnt[0] ? mb[63:32] : mb[31:0];
    pp    = 64'(a_sel) * 64'(b_sel);
    case (cnt)
      2'd0:    pp_sh = 128'(pp);
      2'd3:    pp_sh = 128'(pp) << 64;
      default: pp_sh = 128'(pp) << 32;
    endcase
    t  = {1'b0, acc} + RND;
    sh = t >> FRAC_BITS;
    if (fixm) begin
      ovf = |sh[128:64];
      q   = ovf ? '1 : sh[63:0];
    end else begin
      ovf = |acc[127:64];
      q   = ovf ? '1 : acc[63:0];
    end
    res = from_mag(neg && (q != 64'd0), q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        ma   <= mag64(req.a);
        mb   <= mag64(req.b);
        neg  <= req.a[63] ^ req.b[63];
        fixm <= req.fix;
        acc  <= '0;
        cnt  <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        acc <= acc + pp_sh;
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin      <= 1'b0;
        rsp.done <= 1'b1;
        rsp.sat  <= ovf | res.sat;
        rsp.val  <= res.val;
      end
    end
  end

endmodule

// File: rtl/ale_div.sv
// ----------------------------------------------------------------------------
// ale_div: shared bit-serial divider
// Restoring division of a 64-bit magnitude by a 64-bit divisor, one quotient
// bit per cycle, with optional rounding half away from zero and a saturated
// signed result.
// ----------------------------------------------------------------------------
module ale_div (
  input  logic              clk,
  input  logic              rst,
  input  ale_pkg::div_req_t req,
  output ale_pkg::unit_rsp_t rsp
);
  import ale_pkg::*;

  logic [63:0] num;
  logic [63:0] den;
  logic [64:0] rem;
  logic        rnd;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic        fin;
  logic [64:0] trial;
  logic        ge;
  logic        up;
  logic [63:0] q;
  sat_res_t    res;

  always_comb begin
    trial = {rem[63:0], num[63]};
    ge    = trial >= {1'b0, den};
    up    = rnd && ({rem[63:0], 1'b0} >= {1'b0, den});
    q     = num + 64'(up);
    res   = from_mag(neg && (q != 64'd0), q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        num  <= req.num;
        den  <= req.den;
        rnd  <= req.rnd;
        neg  <= req.neg;
        rem  <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? trial - {1'b0, den} : trial;
        num <= {num[62:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin      <= 1'b0;
        rsp.done <= 1'b1;
        rsp.sat  <= res.sat;
        rsp.val  <= res.val;
      end
    end
  end

endmodule

// File: rtl/associated_legendre_eval.sv
// ----------------------------------------------------------------------------
// associated_legendre_eval: fixed-point associated Legendre function
// Each input transaction carries degree l, signed order m and argument x
// (30 fraction bits, clamped to [-1,1]). One output transaction returns
// P_l^m(x) with the Condon-Shortley phase at FRAC_BITS fraction bits, and a
// status: ok, order magnitude above degree (or degree above L_MAX, value 0),
// or saturated.
// A small sequencer drives one shared multiplier and one bit-serial divider.
// With k = |m|, an item computes the square root, then the 2k - 1 seed
// products, then the step to degree k + 1 (two multiplies), then one
// recurrence step (three multiplies and one division) for each degree
// above k + 1, and for a negative order 2k more products and one division.
// A rejected item goes from idle straight to the result state.
// in_stall is high from the cycle after acceptance until the result is
// placed in the output register; the next transaction is taken while that
// result still waits. While out_stall is high the result holds and the
// block finishes at most one further item.
// Reset clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module associated_legendre_eval #(
  parameter int L_MAX     = 8,
  parameter int FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic        [3:0]  degree,
  input  logic signed [4:0]  order,
  input  logic signed [31:0] arg_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] poly_value,
  output logic        [1:0]  status
);
  import ale_pkg::*;

  localparam int SHL = (FRAC_BITS >= 30) ? FRAC_BITS - 30 : 0;
  localparam int SHR = (FRAC_BITS < 30) ? 30 - FRAC_BITS : 0;
  localparam logic [63:0] RND30 = (64'(1) << SHR) >> 1;
  localparam logic [63:0] ONE_FIX = 64'(1) << FRAC_BITS;
  localparam logic [60:0] ONE_SQ = 61'(1) << 60;

  function automatic logic signed [63:0] to_frac(input logic [63:0] m, input logic neg);
    logic [63:0] v;
    v = (SHR == 0) ? (m << SHL) : ((m + RND30) >> SHR);
    return (neg && (v != 64'd0)) ? $signed(-v) : $signed(v);
  endfunction

  state_t              state;
  state_t              state_next;
  logic [3:0]          l;
  logic [4:0]          k;
  logic                m_neg;
  logic                err;
  logic                sat;
  logic signed [31:0]  x30;
  logic signed [63:0]  xf;
  logic signed [63:0]  s;
  logic [60:0]         u;
  logic [60:0]         r;
  logic [4:0]          it;
  logic signed [63:0]  p;
  logic signed [63:0]  p1;
  logic signed [63:0]  p2;
  logic signed [63:0]  tmp;
  logic signed [63:0]  tmp2;
  logic [63:0]         dprod;
  logic [4:0]          c;
  logic [4:0]          n;
  mul_req_t            mul_req;
  div_req_t            div_req;
  unit_rsp_t           mul_rsp;
  unit_rsp_t           div_rsp;
  logic [4:0]          k_in;
  logic                bad_in;
  logic [30:0]         xm;
  logic [60:0]         bitv;
  logic [60:0]         rb;
  sat_res_t            neg_p;
  sat_res_t            diff;
  logic                out_free;

  ale_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  ale_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    k_in   = order[4] ? 5'(~order + 5'sd1) : 5'(order);
    bad_in = ({1'b0, degree} > 5'(L_MAX)) || (k_in > {1'b0, degree});
    xm     = x30[31] ? 31'(-x30) : 31'(x30);
    bitv   = 61'(1) << {it, 1'b0};
    rb     = r + bitv;
    neg_p  = sub_sat(64'sd0, p);
    diff   = sub_sat(tmp, tmp2);
  end

  always_comb begin
    state_next    = state;
    mul_req       = '0;
    mul_req.a     = p;
    div_req       = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = bad_in ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: state_next = ST_SQRT;
      ST_SQRT: begin
        if (it == 5'd0) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: state_next = ST_POW;
      ST_POW: begin
        if (c == k) begin
          state_next = ST_DFAC;
        end else begin
          mul_req.start = 1'b1;
          mul_req.fix   = 1'b1;
          mul_req.b     = s;
          state_next    = ST_POW_W;
        end
      end
      ST_DFAC: begin
        if (c >= k) begin
          state_next = ST_SIGN;
        end else begin
          mul_req.start = 1'b1;
          mul_req.b     = $signed(64'({c, 1'b1}));
          state_next    = ST_DFAC_W;
        end
      end
      ST_SIGN: state_next = ({1'b0, l} > k) ? ST_X1 : ST_SCALE;
      ST_X1: begin
        mul_req.start = 1'b1;
        mul_req.fix   = 1'b1;
        mul_req.a     = xf;
        mul_req.b     = p2;
        state_next    = ST_X1_W;
      end
      ST_X1B: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmp;
        mul_req.b     = $signed(64'({k, 1'b1}));
        state_next    = ST_X1B_W;
      end
      ST_LOOP: begin
        if (n > {1'b0, l}) begin
          state_next = ST_SCALE;
        end else begin
          mul_req.start = 1'b1;
          mul_req.fix   = 1'b1;
          mul_req.a     = xf;
          mul_req.b     = p1;
          state_next    = ST_LA_W;
        end
      end
      ST_LA2: begin
        mul_req.start = 1'b1;
        mul_req.a     = tmp;
        mul_req.b     = $signed(64'({5'(n - 5'd1), 1'b1}));
        state_next    = ST_LA2_W;
      end
      ST_LB: begin
        mul_req.start = 1'b1;
        mul_req.a     = p2;
        mul_req.b     = $signed(64'(5'(n + k - 5'd1)));
        state_next    = ST_LB_W;
      end
      ST_LDIV: begin
        div_req.start = 1'b1;
        div_req.rnd   = 1'b1;
        div_req.neg   = diff.val[63];
        div_req.num   = mag64(diff.val);
        div_req.den   = 64'(5'(n - k));
        state_next    = ST_LDIV_W;
      end
      ST_SCALE: state_next = m_neg ? ST_DPROD : ST_DONE;
      ST_DPROD: begin
        if (c > 5'(5'(l) + k)) begin
          state_next = ST_FDIV;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = $signed(dprod);
          mul_req.b     = $signed(64'(c));
          state_next    = ST_DPROD_W;
        end
      end
      ST_FDIV: begin
        div_req.start = 1'b1;
        div_req.neg   = p[63] ^ k[0];
        div_req.num   = mag64(p);
        div_req.den   = dprod;
        state_next    = ST_FDIV_W;
      end
      ST_POW_W:   if (mul_rsp.done) state_next = ST_POW;
      ST_DFAC_W:  if (mul_rsp.done) state_next = ST_DFAC;
      ST_X1_W:    if (mul_rsp.done) state_next = ST_X1B;
      ST_X1B_W:   if (mul_rsp.done) state_next = ST_LOOP;
      ST_LA_W:    if (mul_rsp.done) state_next = ST_LA2;
      ST_LA2_W:   if (mul_rsp.done) state_next = ST_LB;
      ST_LB_W:    if (mul_rsp.done) state_next = ST_LDIV;
      ST_DPROD_W: if (mul_rsp.done) state_next = ST_DPROD;
      ST_LDIV_W:  if (div_rsp.done) state_next = ST_LOOP;
      ST_FDIV_W:  if (div_rsp.done) state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sat       <= 1'b0;
      err       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      if ((state != ST_IDLE) &&
          ((mul_rsp.done && mul_rsp.sat) || (div_rsp.done && div_rsp.sat))) begin
        sat <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            l     <= degree;
            k     <= k_in;
            m_neg <= order[4];
            err   <= bad_in;
            sat   <= 1'b0;
            if (arg_value > 32'sd1073741824) begin
              x30 <= 32'sd1073741824;
            end else if (arg_value < -32'sd1073741824) begin
              x30 <= -32'sd1073741824;
            end else begin
              x30 <= arg_value;
            end
          end
        end
        ST_PREP: begin
          u  <= ONE_SQ - 61'(62'(xm) * 62'(xm));
          xf <= to_frac(64'(xm), x30[31]);
          r  <= '0;
          it <= 5'd30;
        end
        ST_SQRT: begin
          if (u >= rb) begin
            u <= u - rb;
            r <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          it <= it - 5'd1;
        end
        ST_ROOT: begin
          s <= to_frac(64'(r), 1'b0);
          p <= $signed(ONE_FIX);
          c <= '0;
        end
        ST_POW: begin
          if (c == k) begin
            c <= 5'd1;
          end
        end
        ST_POW_W, ST_DFAC_W: begin
          if (mul_rsp.done) begin
            p <= mul_rsp.val;
            c <= c + 5'd1;
          end
        end
        ST_SIGN: begin
          if (k[0]) begin
            p  <= neg_p.val;
            p2 <= neg_p.val;
            if (neg_p.sat) begin
              sat <= 1'b1;
            end
          end else begin
            p2 <= p;
          end
        end
        ST_X1_W, ST_LA_W, ST_LA2_W: begin
          if (mul_rsp.done) begin
            tmp <= mul_rsp.val;
          end
        end
        ST_X1B_W: begin
          if (mul_rsp.done) begin
            p1 <= mul_rsp.val;
            n  <= k + 5'd2;
          end
        end
        ST_LOOP: begin
          if (n > {1'b0, l}) begin
            p <= p1;
          end
        end
        ST_LB_W: begin
          if (mul_rsp.done) begin
            tmp2 <= mul_rsp.val;
          end
        end
        ST_LDIV: begin
          p2 <= p1;
          if (diff.sat) begin
            sat <= 1'b1;
          end
        end
        ST_LDIV_W: begin
          if (div_rsp.done) begin
            p1 <= div_rsp.val;
            n  <= n + 5'd1;
          end
        end
        ST_SCALE: begin
          dprod <= 64'd1;
          c     <= 5'(5'(l) - k + 5'd1);
        end
        ST_DPROD_W: begin
          if (mul_rsp.done) begin
            dprod <= 64'(mul_rsp.val);
            c     <= c + 5'd1;
          end
        end
        ST_FDIV_W: begin
          if (div_rsp.done) begin
            p <= div_rsp.val;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            poly_value <= err ? 64'sd0 : p;
            status     <= err ? STATUS_RANGE : (sat ? STATUS_SAT : STATUS_OK);
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_RANGE) |-> poly_value == 64'sd0)
    else $error("range status with nonzero value");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer accepted a transaction without going busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK) || (status == STATUS_RANGE) ||
                  (status == STATUS_SAT))
    else $error("undefined status code");

  a_units_excl: assert property (@(posedge clk) disable iff (rst)
    !(mul_rsp.done && div_rsp.done))
    else $error("multiplier and divider finished together");

  a_err_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && in_valid && bad_in |=> state == ST_DONE)
    else $error("rejected item did not go straight to the result");

endmodule
